[sv/epd_pkg.sv]
package epd_pkg;

  localparam logic [7:0] DELIM_BYTE   = 8'h2B;
  localparam logic [7:0] ESC_BYTE     = 8'd17;
  localparam logic [4:0] CHANNEL_MASK = 5'h1F;
  localparam logic [7:0] MIN_FRAME    = 8'd2;
  localparam logic [7:0] MAX_LEN_RST  = 8'd64;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD      = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_DELIM = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } q_entry_t;

endpackage

[sv/epd_front.sv]
module epd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              push,
  output epd_pkg::q_entry_t push_entry,
  input  logic              q_ready
);
  import epd_pkg::*;

  logic esc_r;
  logic esc_nxt;
  logic take;
  logic emit;

  assign in_ready = q_ready;
  assign take     = in_valid && q_ready;

  // An escaped word is always passed on as data; the back end decides
  // whether it is stored or dropped while discarding.
  always_comb begin
    esc_nxt          = esc_r;
    emit             = 1'b0;
    push_entry.op    = OP_DATA;
    push_entry.value = in_rx_byte;
    if (esc_r) begin
      emit    = 1'b1;
      esc_nxt = 1'b0;
    end else if (in_rx_byte == ESC_BYTE) begin
      esc_nxt = 1'b1;
    end else if (in_rx_byte == DELIM_BYTE) begin
      emit          = 1'b1;
      push_entry.op = OP_DELIM;
    end else begin
      emit = 1'b1;
    end
  end

  assign push = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else if (take) begin
      esc_r <= esc_nxt;
    end
  end

endmodule

[sv/epd_queue.sv]
module epd_queue #(
  parameter int DEPTH = epd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  epd_pkg::q_entry_t push_entry,
  output logic              q_ready,
  output logic              pop_valid,
  output epd_pkg::q_entry_t pop_entry,
  input  logic              pop
);
  import epd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign q_ready   = (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

[sv/epd_back.sv]
module epd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_max_length,
  input  logic              pop_valid,
  input  epd_pkg::q_entry_t pop_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_end,
  output logic [7:0]        out_byte_index,
  output logic [7:0]        out_data_byte,
  output logic [1:0]        out_status,
  output logic [7:0]        out_frame_length,
  output logic [4:0]        out_channel
);
  import epd_pkg::*;

  logic [7:0] max_length_r;
  logic [7:0] stored_count_r;
  logic [7:0] stored_count_nxt;
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [4:0] channel_r;
  logic [4:0] channel_nxt;
  logic       discard_r;
  logic       discard_nxt;
  logic [7:0] limit;
  logic [7:0] count_inc;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_is_end_r;
  logic [7:0] out_byte_index_r;
  logic [7:0] out_data_byte_r;
  logic [1:0] out_status_r;
  logic [7:0] out_frame_length_r;
  logic [4:0] out_channel_r;
  logic       load;

  assign pop       = pop_valid && (!out_valid_r || out_ready);
  assign limit     = (max_length_r == 8'd0) ? 8'd1 : max_length_r;
  assign count_inc = stored_count_r + 8'd1;

  always_comb begin
    stored_count_nxt = stored_count_r;
    xor_nxt          = xor_r;
    channel_nxt      = channel_r;
    discard_nxt      = discard_r;
    load             = 1'b0;
    if (pop) begin
      if (pop_entry.op == OP_DELIM) begin
        load             = 1'b1;
        stored_count_nxt = 8'd0;
        xor_nxt          = 8'd0;
        channel_nxt      = 5'd0;
        discard_nxt      = 1'b0;
      end else if (!discard_r) begin
        load             = 1'b1;
        stored_count_nxt = count_inc;
        xor_nxt          = xor_r ^ pop_entry.value;
        if (stored_count_r == 8'd0) begin
          channel_nxt = pop_entry.value[4:0] & CHANNEL_MASK;
        end
        discard_nxt = (count_inc >= limit);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r   <= MAX_LEN_RST;
      stored_count_r <= 8'd0;
      xor_r          <= 8'd0;
      channel_r      <= 5'd0;
      discard_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_length_r <= cfg_max_length;
      end
      stored_count_r <= stored_count_nxt;
      xor_r          <= xor_nxt;
      channel_r      <= channel_nxt;
      discard_r      <= discard_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pop_entry.op == OP_DELIM) begin
        out_is_end_r       <= 1'b1;
        out_byte_index_r   <= 8'd0;
        out_data_byte_r    <= 8'd0;
        out_frame_length_r <= stored_count_r;
        out_channel_r      <= channel_r;
        if (discard_r) begin
          out_status_r <= STATUS_OVERFLOW;
        end else if ((xor_r == 8'd0) && (stored_count_r >= MIN_FRAME)) begin
          out_status_r <= STATUS_OK;
        end else begin
          out_status_r <= STATUS_BAD;
        end
      end else begin
        out_is_end_r       <= 1'b0;
        out_byte_index_r   <= stored_count_r;
        out_data_byte_r    <= pop_entry.value;
        out_status_r       <= STATUS_OK;
        out_frame_length_r <= 8'd0;
        out_channel_r      <= 5'd0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_end       = out_is_end_r;
  assign out_byte_index   = out_byte_index_r;
  assign out_data_byte    = out_data_byte_r;
  assign out_status       = out_status_r;
  assign out_frame_length = out_frame_length_r;
  assign out_channel      = out_channel_r;

`ifndef SYNTH
  // Discarding only starts after at least one word was stored.
  a_discard_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (stored_count_r != 8'd0))
    else $error("discarding with an empty frame");

  // A delimiter always leaves the frame state cleared.
  a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (pop_entry.op == OP_DELIM)) |=>
      ((stored_count_r == 8'd0) && (xor_r == 8'd0) && !discard_r && out_valid_r))
    else $error("frame state not cleared after delimiter");

  // A stored word is presented with the index it had before the count moved.
  a_store_index: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (pop_entry.op == OP_DATA) && !discard_r) |=>
      (out_valid_r && !out_is_end_r && (out_byte_index_r == stored_count_r - 8'd1)))
    else $error("stored word index mismatch");
`endif

endmodule

[sv/escaped_packet_deframer_unit.sv]
// Channel  | Ports                                        | Direction
// ---------+----------------------------------------------+----------
// in       | in_valid, in_ready, in_rx_byte               | input word
// out      | out_valid, out_ready, out_is_end, out_byte_index,
//          | out_data_byte, out_status, out_frame_length, | result word
//          | out_channel                                  |
// cfg      | cfg_valid, cfg_ready, cfg_max_length         | register write
//
// One word per cycle is sustained while the queue is not full; a word is
// written into the queue as it is accepted (escape decode on the way in),
// and the back end updates the output register as the word leaves it.
// The queue of QUEUE_DEPTH entries lets the input keep running while a
// result waits on out_ready; in_ready drops only when the queue is full.
// Reset is synchronous and leaves no frame open, max_length at 64.
// cfg_ready is always high.
module escaped_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = epd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_end,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  output logic [7:0] out_frame_length,
  output logic [4:0] out_channel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_max_length
);
  import epd_pkg::*;

  logic     push;
  q_entry_t push_entry;
  logic     q_ready;
  logic     pop_valid;
  q_entry_t pop_entry;
  logic     pop;

  assign cfg_ready = 1'b1;

  epd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  epd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop        (pop)
  );

  epd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_max_length   (cfg_max_length),
    .pop_valid        (pop_valid),
    .pop_entry        (pop_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_end       (out_is_end),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_channel      (out_channel)
  );

endmodule

[test/tb.sv]
module tb;
  import epd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;

  typedef enum logic [1:0] {
    RX_NORMAL,
    RX_ESCAPED,
    RX_DISCARD,
    RX_DISCARD_ESC
  } rx_mode_t;

  typedef struct packed {
    logic       is_end;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] frame_length;
    logic [4:0] channel;
  } deframe_result_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte     = 8'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic       out_is_end;
  logic [7:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic [1:0] out_status;
  logic [7:0] out_frame_length;
  logic [4:0] out_channel;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_max_length = 8'd0;

  // Predicted deframer state and register copy.
  rx_mode_t   pred_mode;
  logic [7:0] pred_count;
  logic [7:0] pred_xor;
  logic [4:0] pred_channel;
  logic [7:0] pred_max_len;

  deframe_result_t expected_results[$];
  int errors;
  int in_idle_pct;
  int out_idle_pct;
  int words_sent;
  int quiet_cycles;

  always #5 clk = ~clk;

  escaped_packet_deframer_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_end      (out_is_end),
    .out_byte_index  (out_byte_index),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_frame_length(out_frame_length),
    .out_channel     (out_channel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_length  (cfg_max_length)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch(name, got, want);
  endtask

  task automatic store_predicted(input logic [7:0] b);
    logic [7:0] limit;
    deframe_result_t r;
    limit = (pred_max_len == 8'd0) ? 8'd1 : pred_max_len;
    r = '0;
    r.byte_index = pred_count;
    r.data_byte  = b;
    expected_results.push_back(r);
    if (pred_count == 8'd0) pred_channel = b[4:0] & CHANNEL_MASK;
    pred_xor   = pred_xor ^ b;
    pred_count = pred_count + 8'd1;
    pred_mode  = (pred_count >= limit) ? RX_DISCARD : RX_NORMAL;
  endtask

  task automatic end_predicted(input logic [1:0] status);
    deframe_result_t r;
    r = '0;
    r.is_end       = 1'b1;
    r.status       = status;
    r.frame_length = pred_count;
    r.channel      = pred_channel;
    expected_results.push_back(r);
    pred_mode    = RX_NORMAL;
    pred_count   = 8'd0;
    pred_xor     = 8'd0;
    pred_channel = 5'd0;
  endtask

  task automatic predict_deframe(input logic [7:0] b);
    case (pred_mode)
      RX_ESCAPED: begin
        store_predicted(b);
      end
      RX_DISCARD: begin
        if (b == ESC_BYTE) pred_mode = RX_DISCARD_ESC;
        else if (b == DELIM_BYTE) end_predicted(STATUS_OVERFLOW);
      end
      RX_DISCARD_ESC: begin
        pred_mode = RX_DISCARD;
      end
      default: begin
        if (b == DELIM_BYTE) begin
          end_predicted((pred_xor == 8'd0 && pred_count >= MIN_FRAME) ? STATUS_OK : STATUS_BAD);
        end else if (b == ESC_BYTE) begin
          pred_mode = RX_ESCAPED;
        end else begin
          store_predicted(b);
        end
      end
    endcase
  endtask

  // The word stays on the port until in_ready takes it; the next call either
  // replaces it or an idle cycle lowers valid at the following falling edge.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deframe(b);
    words_sent++;
  endtask

  // Lowers valid, waits for every expected result, then lets words that
  // cause no result drain through the pipeline.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] value);
    wait_idle();
    cfg_valid      <= 1'b1;
    cfg_max_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_max_len = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bytes that collide with a control code are always escaped; others are
  // escaped now and then, which the framing allows.
  task automatic send_stored(input logic [7:0] b);
    if (b == ESC_BYTE || b == DELIM_BYTE || $urandom_range(7) == 0) send_byte(ESC_BYTE);
    send_byte(b);
  endtask

  task automatic send_frame(input int len, input bit good);
    logic [7:0] b;
    logic [7:0] sum;
    sum = 8'd0;
    for (int k = 0; k < len; k++) begin
      b = (good && k == len - 1 && len >= 2) ? sum : 8'($urandom_range(255));
      sum = sum ^ b;
      send_stored(b);
    end
    send_byte(DELIM_BYTE);
  endtask

  task automatic test_frames();
    // Good frame at the reset limit, header with every channel bit set.
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(DELIM_BYTE);
    // Escaped delimiter as header and an escaped escape; checksum is wrong.
    send_byte(ESC_BYTE);
    send_byte(DELIM_BYTE);
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    send_byte(DELIM_BYTE);
    // Zero checksum but a single stored byte is too short.
    send_byte(8'h00);
    send_byte(DELIM_BYTE);
    // Delimiter with nothing stored.
    send_byte(DELIM_BYTE);
  endtask

  task automatic test_overflow();
    write_max_length(8'd1);
    send_byte(8'hA5);
    send_byte(8'h01);
    // An escaped delimiter while discarding must not close the frame.
    send_byte(ESC_BYTE);
    send_byte(DELIM_BYTE);
    send_byte(DELIM_BYTE);
    // An escaped escape reaches the limit as the header.
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    send_byte(DELIM_BYTE);
  endtask

  task automatic test_limit_lowered();
    write_max_length(8'd255);
    send_byte(8'h21);
    send_byte(8'h42);
    send_byte(8'h84);
    // The frame is still open while the limit drops below its count.
    write_max_length(8'd2);
    send_byte(8'h7E);
    send_byte(DELIM_BYTE);
  endtask

  task automatic test_random(input int idle_in, input int idle_out);
    logic [7:0] setting;
    int target;
    int len;
    in_idle_pct  = idle_in;
    out_idle_pct = idle_out;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0:       setting = 8'($urandom_range(16, 2));
        1:       setting = 8'd1;
        2:       setting = 8'd255;
        default: setting = 8'($urandom_range(254, 17));
      endcase
      write_max_length(setting);
      target = words_sent + 85;
      while (words_sent < target) begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(2))
            0:       send_byte(ESC_BYTE);
            1:       send_byte(DELIM_BYTE);
            default: send_byte(8'($urandom_range(255)));
          endcase
        end else begin
          // Now and then a frame sized around a small limit to hit overflow.
          if ($urandom_range(15) == 0 && pred_max_len <= 8'd32) begin
            len = int'(pred_max_len) + $urandom_range(2) - 1;
          end else begin
            len = $urandom_range(10);
          end
          send_frame(len, $urandom_range(3) != 0);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin : check_results
    deframe_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", out_is_end, 0);
      end else begin
        want = expected_results.pop_front();
        check_field("is_end", out_is_end, want.is_end);
        check_field("byte_index", out_byte_index, want.byte_index);
        check_field("data_byte", out_data_byte, want.data_byte);
        check_field("status", out_status, want.status);
        check_field("frame_length", out_frame_length, want.frame_length);
        check_field("channel", out_channel, want.channel);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors       = 0;
    words_sent   = 0;
    in_idle_pct  = 19;
    out_idle_pct = 48;
    pred_mode    = RX_NORMAL;
    pred_count   = 8'd0;
    pred_xor     = 8'd0;
    pred_channel = 5'd0;
    pred_max_len = MAX_LEN_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_frames();
    test_overflow();
    test_limit_lowered();
    test_random(19, 48);
    test_random(48, 19);
    test_random(0, 0);

    wait_idle();
    if (expected_results.size() != 0) begin
      report_mismatch("results left over", 0, expected_results.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
